### hw/rtl/tse_pkg.sv
package tse_pkg;

   localparam int DEFAULT_RING_DEPTH  = 131072;
   localparam int DEFAULT_SAMPLE_BITS = 24;

   localparam int CFG_W       = 18;
   localparam int STOP_W      = 17;
   localparam int RAMP_W      = 16;
   localparam int FRAC_W      = 16;
   localparam int RATE_NOW_W  = 34;
   localparam int QUO_W       = 33;
   localparam int CSR_INDEX_W = 2;

   localparam logic [STOP_W-1:0] ONE_Q16 = STOP_W'(65536);

   localparam logic [CFG_W-1:0]  RST_RING_LENGTH      = CFG_W'(88200);
   localparam logic [RAMP_W-1:0] RST_RAMP_SAMPLES     = RAMP_W'(1323);
   localparam logic [STOP_W-1:0] RST_ACTIVE_THRESHOLD = STOP_W'(7);

   localparam logic [CSR_INDEX_W-1:0] CSR_RING_LENGTH      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SAMPLES     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO_ENABLE    = 2'd3;

endpackage

### hw/rtl/tape_stop_effect.sv
// channel   direction  tdata (low to high)                       tuser / tlast
// req_      in         left_in, right_in, stop_amount, zero pad  none
// rsp_      out        left_out, right_out, zero pad             none
// csr_      in         write only: index 0..3, data 18 bits      none
// dry item: states GOAL, STEP, WRITE, OUT; wet item: RDA, RDB, M1 to M5 come between WRITE and OUT
// req_tready returns together with the load of the result register
// a change of target rate with a ramp adds a 33-step serial divide
// one shared multiplier does both interpolations and both gain stages in turn
// after reset the history is zeroed one entry a cycle, all RING_DEPTH entries, req_tready low
// a result waiting in the output register stalls the next item only at its end
module tape_stop_effect #(
   parameter int RING_DEPTH  = tse_pkg::DEFAULT_RING_DEPTH,
   parameter int SAMPLE_BITS = tse_pkg::DEFAULT_SAMPLE_BITS,
   localparam int REQ_W = ((2 * SAMPLE_BITS + tse_pkg::STOP_W + 7) / 8) * 8,
   localparam int RSP_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,  // left_in, right_in, stop_amount
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,  // left_out, right_out
   input  logic                              csr_we,
   input  logic [tse_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tse_pkg::CFG_W-1:0]         csr_wdata
);
   localparam int SB  = SAMPLE_BITS;
   localparam int AW  = $clog2(RING_DEPTH);
   localparam int LW  = AW + 1;
   localparam int FW  = tse_pkg::FRAC_W;
   localparam int PW  = AW + FW + 1;
   localparam int MA  = SB + 1;
   localparam int MB  = 18;
   localparam int MP  = MA + MB;
   localparam int SW  = tse_pkg::STOP_W;
   localparam int RW  = tse_pkg::RATE_NOW_W;
   localparam int CMW = ((LW > tse_pkg::CFG_W) ? LW : tse_pkg::CFG_W) + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_GOAL, S_DIV, S_STEP, S_WRITE, S_RDA, S_RDB,
      S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
   } state_type;

   state_type                   state_ff;
   logic [tse_pkg::CFG_W-1:0]   ring_len_ff;
   logic [tse_pkg::RAMP_W-1:0]  ramp_ff;
   logic [SW-1:0]               thresh_ff;
   logic                        stereo_ff;

   logic [AW-1:0]               clr_addr_ff;
   logic [AW-1:0]               wi_ff;
   logic [PW-1:0]               pos_ff;
   logic                        was_ff;
   logic signed [RW-1:0]        rate_now_ff;
   logic [SW-1:0]               rate_goal_ff;
   logic signed [RW-1:0]        rate_inc_ff;
   logic [tse_pkg::RAMP_W-1:0]  ramp_rem_ff;
   logic                        rsp_valid_ff;
   logic [2*SB-1:0]             rsp_data_ff;

   logic signed [SB-1:0]        l_ff, r_ff;
   logic                        active_ff;
   logic [SW-1:0]               goal_ff;
   logic [2*SB-1:0]             sa_ff, sb_ff, rd_ff;
   logic signed [MA-1:0]        ipl_ff, ipr_ff;
   logic signed [SB-1:0]        out_l_ff, out_r_ff;

   logic [2*SB-1:0]             mem [RING_DEPTH];

   logic [CMW-1:0]              ring_ext_in;
   logic [LW-1:0]               len_in;
   logic [SW-1:0]               stop_in;
   logic [AW-1:0]               wi_fix_in;
   logic [LW-1:0]               wi_inc_in;
   logic [LW-1:0]               a_in;
   logic [LW-1:0]               b_in;
   logic [SW-1:0]               rate_use_in;
   logic [PW-1:0]               pos_adv_in;
   logic [PW-1:0]               len_pos_in;
   logic                        mem_we_in;
   logic [AW-1:0]               mem_waddr_in;
   logic [2*SB-1:0]             mem_wdata_in;
   logic [AW-1:0]               mem_raddr_in;
   logic signed [MA-1:0]        mul_a_in;
   logic signed [MB-1:0]        mul_b_in;
   logic signed [MP-1:0]        prod;
   logic signed [MP-1:0]        rnd_in;
   logic signed [MA-1:0]        sa_sel_in;
   logic signed [MA-1:0]        ip_in;
   logic                        div_start_in;
   logic signed [RW-1:0]        div_numer_in;
   logic                        div_done;
   logic signed [RW-1:0]        div_q;

   // clamp the history length
   always_comb begin
      ring_ext_in = CMW'(ring_len_ff);
      if (ring_ext_in < CMW'(2))
         len_in = LW'(2);
      else if (ring_ext_in > CMW'(RING_DEPTH))
         len_in = LW'(RING_DEPTH);
      else
         len_in = LW'(ring_ext_in);
   end

   assign stop_in     = (req_tdata[2*SB +: SW] > tse_pkg::ONE_Q16) ? tse_pkg::ONE_Q16
                                                                 : req_tdata[2*SB +: SW];
   assign wi_fix_in   = (LW'(wi_ff) >= len_in) ? '0 : wi_ff;
   assign wi_inc_in   = LW'(wi_ff) + LW'(1);
   assign rate_use_in = rate_now_ff[FW +: SW];
   assign a_in        = LW'(pos_ff[FW +: AW]);
   assign b_in        = ((a_in + LW'(1)) >= len_in) ? '0 : a_in + LW'(1);
   assign len_pos_in  = {len_in, {FW{1'b0}}};
   assign pos_adv_in  = ((pos_ff + PW'(rate_use_in)) >= len_pos_in)
                        ? pos_ff + PW'(rate_use_in) - len_pos_in
                        : pos_ff + PW'(rate_use_in);
   assign div_numer_in = $signed({1'b0, goal_ff, {FW{1'b0}}}) - rate_now_ff;
   assign div_start_in = (state_ff == S_GOAL) && (goal_ff != rate_goal_ff)
                         && (ramp_ff != '0);

   // history port
   always_comb begin
      mem_we_in    = 1'b0;
      mem_waddr_in = wi_ff;
      mem_wdata_in = {r_ff, l_ff};
      mem_raddr_in = a_in[AW-1:0];
      case (state_ff)
         S_CLEAR: begin
            mem_we_in    = 1'b1;
            mem_waddr_in = clr_addr_ff;
            mem_wdata_in = '0;
         end
         S_WRITE: mem_we_in = 1'b1;
         S_RDB:   mem_raddr_in = b_in[AW-1:0];
         default: mem_we_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we_in)
         mem[mem_waddr_in] <= mem_wdata_in;
      rd_ff <= mem[mem_raddr_in];
   end

   // shared multiplier operands
   always_comb begin
      mul_a_in  = '0;
      mul_b_in  = $signed({2'b00, pos_ff[FW-1:0]});
      sa_sel_in = MA'($signed(sa_ff[SB-1:0]));
      case (state_ff)
         S_M1: mul_a_in = MA'($signed(rd_ff[SB-1:0])) - MA'($signed(sa_ff[SB-1:0]));
         S_M2: begin
            mul_a_in = MA'($signed(sb_ff[2*SB-1:SB])) - MA'($signed(sa_ff[2*SB-1:SB]));
         end
         S_M3: begin
            mul_a_in  = ipl_ff;
            mul_b_in  = $signed({1'b0, rate_use_in});
            sa_sel_in = MA'($signed(sa_ff[2*SB-1:SB]));
         end
         S_M4: begin
            mul_a_in = ipr_ff;
            mul_b_in = $signed({1'b0, rate_use_in});
         end
         default: mul_a_in = '0;
      endcase
   end

   assign rnd_in = (prod + MP'(32768)) >>> FW;
   assign ip_in  = sa_sel_in + MA'(rnd_in);

   tse_mul #(.A_W(MA), .B_W(MB)) u_mul (
      .clock   (clock),
      .op_a    (mul_a_in),
      .op_b    (mul_b_in),
      .product (prod)
   );

   tse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_in),
      .numer    (div_numer_in),
      .denom    (ramp_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         wi_ff        <= '0;
         pos_ff       <= '0;
         was_ff       <= 1'b0;
         rate_now_ff  <= RW'(64'd1 << 32);
         rate_goal_ff <= tse_pkg::ONE_Q16;
         rate_inc_ff  <= '0;
         ramp_rem_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         ring_len_ff  <= tse_pkg::RST_RING_LENGTH;
         ramp_ff      <= tse_pkg::RST_RAMP_SAMPLES;
         thresh_ff    <= tse_pkg::RST_ACTIVE_THRESHOLD;
         stereo_ff    <= 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tse_pkg::CSR_RING_LENGTH:      ring_len_ff <= csr_wdata;
               tse_pkg::CSR_RAMP_SAMPLES:     ramp_ff     <= csr_wdata[tse_pkg::RAMP_W-1:0];
               tse_pkg::CSR_ACTIVE_THRESHOLD: thresh_ff   <= csr_wdata[SW-1:0];
               tse_pkg::CSR_STEREO_ENABLE:    stereo_ff   <= csr_wdata[0];
               default:                       stereo_ff   <= stereo_ff;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT))
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == AW'(RING_DEPTH - 1))
                  state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  l_ff      <= $signed(req_tdata[SB-1:0]);
                  r_ff      <= stereo_ff ? $signed(req_tdata[2*SB-1:SB]) : '0;
                  active_ff <= stop_in > thresh_ff;
                  goal_ff   <= (stop_in > thresh_ff) ? tse_pkg::ONE_Q16 - stop_in
                                                     : tse_pkg::ONE_Q16;
                  wi_ff     <= wi_fix_in;
                  state_ff  <= S_GOAL;
               end
            end
            S_GOAL: begin
               if (goal_ff != rate_goal_ff) begin
                  rate_goal_ff <= goal_ff;
                  if (ramp_ff == '0) begin
                     rate_now_ff <= $signed({1'b0, goal_ff, {FW{1'b0}}});
                     ramp_rem_ff <= '0;
                     state_ff    <= S_STEP;
                  end else begin
                     ramp_rem_ff <= ramp_ff;
                     state_ff    <= S_DIV;
                  end
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  rate_inc_ff <= div_q;
                  state_ff    <= S_STEP;
               end
            end
            S_STEP: begin
               if (ramp_rem_ff != '0) begin
                  ramp_rem_ff <= ramp_rem_ff - 1'b1;
                  if (ramp_rem_ff != tse_pkg::RAMP_W'(1))
                     rate_now_ff <= rate_now_ff + rate_inc_ff;
                  else
                     rate_now_ff <= $signed({1'b0, rate_goal_ff, {FW{1'b0}}});
               end
               if (!active_ff || !was_ff)
                  pos_ff <= {1'b0, wi_ff, {FW{1'b0}}};
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (active_ff) begin
                  if (LW'(pos_ff[PW-1:FW]) >= len_in)
                     pos_ff <= PW'(pos_ff[FW-1:0]);
                  state_ff <= S_RDA;
               end else begin
                  out_l_ff <= l_ff;
                  out_r_ff <= r_ff;
                  state_ff <= S_OUT;
               end
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               sa_ff    <= rd_ff;
               state_ff <= S_M1;
            end
            S_M1: begin
               sb_ff    <= rd_ff;
               state_ff <= S_M2;
            end
            S_M2: begin
               ipl_ff   <= ip_in;
               state_ff <= S_M3;
            end
            S_M3: begin
               ipr_ff   <= ip_in;
               state_ff <= S_M4;
            end
            S_M4: begin
               out_l_ff <= rnd_in[SB-1:0];
               state_ff <= S_M5;
            end
            S_M5: begin
               out_r_ff <= stereo_ff ? rnd_in[SB-1:0] : '0;
               pos_ff   <= pos_adv_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {out_r_ff, out_l_ff};
                  was_ff       <= active_ff;
                  wi_ff        <= (wi_inc_in >= len_in) ? '0 : wi_inc_in[AW-1:0];
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
endmodule

### hw/rtl/tse_div.sv
module tse_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tse_pkg::RATE_NOW_W-1:0] numer,
   input  logic [tse_pkg::RAMP_W-1:0]           denom,
   output logic                                 done,
   output logic signed [tse_pkg::RATE_NOW_W-1:0] quotient
);
   localparam int QW = tse_pkg::QUO_W;
   localparam int DW = tse_pkg::RAMP_W;
   localparam int CW = $clog2(QW + 1);

   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic                   neg_ff;
   logic [DW-1:0]          rem_ff;
   logic [QW-1:0]          quo_ff;
   logic [DW-1:0]          den_ff;
   logic [DW:0]            trial_in;
   logic                   bit_in;
   logic [tse_pkg::RATE_NOW_W-1:0] abs_in;

   assign abs_in   = numer[tse_pkg::RATE_NOW_W-1] ? -numer : numer;
   assign trial_in = {rem_ff, quo_ff[QW-1]};
   assign bit_in   = trial_in >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW);
            rem_ff  <= '0;
            quo_ff  <= abs_in[QW-1:0];
            neg_ff  <= numer[tse_pkg::RATE_NOW_W-1];
            den_ff  <= denom;
         end else if (busy_ff) begin
            rem_ff <= bit_in ? DW'(trial_in - {1'b0, den_ff}) : trial_in[DW-1:0];
            quo_ff <= {quo_ff[QW-2:0], bit_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1))
               busy_ff <= 1'b0;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

### hw/rtl/tse_mul.sv
module tse_mul #(
   parameter int A_W = tse_pkg::DEFAULT_SAMPLE_BITS + 1,
   parameter int B_W = 18
) (
   input  logic                    clock,
   input  logic signed [A_W-1:0]   op_a,
   input  logic signed [B_W-1:0]   op_b,
   output logic signed [A_W+B_W-1:0] product
);
   logic signed [A_W+B_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;
endmodule

### verif/tape_stop_effect_tb.sv
module tape_stop_effect_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = tse_pkg::DEFAULT_RING_DEPTH;
   localparam int SB    = tse_pkg::DEFAULT_SAMPLE_BITS;
   localparam int REQ_W = ((2 * SB + tse_pkg::STOP_W + 7) / 8) * 8;
   localparam int RSP_W = ((2 * SB + 7) / 8) * 8;
   localparam int IDLE_LIMIT = 2 * DEPTH + 20000;

   typedef struct packed {
      logic [SB-1:0] right;
      logic [SB-1:0] left;
   } pair_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [tse_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [tse_pkg::CFG_W-1:0] csr_wdata = '0;

   tape_stop_effect uut (.*);

   initial forever #10 clock = ~clock;

   // predictor state
   logic signed [SB-1:0] hist_l [DEPTH];
   logic signed [SB-1:0] hist_r [DEPTH];
   int unsigned wr_idx;
   longint unsigned rd_pos;
   bit engaged_prev;
   longint signed speed, speed_step;
   int unsigned speed_goal, ramp_left;
   int unsigned cfg_len, cfg_ramp, cfg_thresh, cfg_stereo;

   pair_type expected_q[$];
   int errors, sent, got, idle_cycles;
   int send_idle_pct, recv_idle_pct;
   bit recv_hold;

   task automatic report(string what, longint e, longint a);
      $display("mismatch %s: expected %0d got %0d", what, e, a);
      errors++;
   endtask

   function automatic longint signed rnd16(longint signed x);
      longint signed y;
      y = x + 32768;
      if (y >= 0) return y >>> 16;
      return -(((-y) + 65535) >>> 16);
   endfunction

   function automatic longint signed lerp_hist(bit right, int unsigned len,
                                               longint unsigned pos);
      int unsigned a, b;
      longint signed sa, sb, fr;
      a = pos >> 16;
      b = a + 1;
      fr = pos & 64'hFFFF;
      if (b >= len) b = 0;
      sa = right ? hist_r[a % DEPTH] : hist_l[a % DEPTH];
      sb = right ? hist_r[b % DEPTH] : hist_l[b % DEPTH];
      return sa + rnd16(fr * (sb - sa));
   endfunction

   function automatic pair_type predict_tape_stop(logic signed [SB-1:0] l_in,
                                                  logic signed [SB-1:0] r_in,
                                                  logic [tse_pkg::STOP_W-1:0] stop_in);
      int unsigned len, stop, goal, spd;
      longint signed l, r, ol, orr;
      bit on;
      pair_type res;
      len = cfg_len < 2 ? 2 : (cfg_len > DEPTH ? DEPTH : cfg_len);
      if (wr_idx >= len) wr_idx = 0;
      l = l_in;
      r = cfg_stereo ? longint'(r_in) : 0;
      stop = stop_in > tse_pkg::ONE_Q16 ? tse_pkg::ONE_Q16 : stop_in;
      on = stop > cfg_thresh;
      goal = on ? tse_pkg::ONE_Q16 - stop : tse_pkg::ONE_Q16;
      if (goal != speed_goal) begin
         speed_goal = goal;
         if (cfg_ramp == 0) begin
            speed = longint'(goal) << 16;
            ramp_left = 0;
         end else begin
            ramp_left = cfg_ramp;
            speed_step = ((longint'(goal) << 16) - speed) / longint'(cfg_ramp);
         end
      end
      hist_l[wr_idx] = l;
      hist_r[wr_idx] = r;
      if (!on || !engaged_prev) rd_pos = longint'(wr_idx) << 16;
      if (ramp_left != 0) begin
         ramp_left--;
         if (ramp_left != 0) speed += speed_step;
         else speed = longint'(speed_goal) << 16;
      end
      spd = speed >>> 16;
      if (!on) begin
         ol = l;
         orr = r;
      end else begin
         if ((rd_pos >> 16) >= len) rd_pos &= 64'hFFFF;
         ol = rnd16(lerp_hist(0, len, rd_pos) * longint'(spd));
         orr = rnd16(lerp_hist(1, len, rd_pos) * longint'(spd));
         rd_pos += spd;
         if (rd_pos >= (longint'(len) << 16)) rd_pos -= longint'(len) << 16;
      end
      if (!cfg_stereo) orr = 0;
      engaged_prev = on;
      wr_idx++;
      if (wr_idx >= len) wr_idx = 0;
      res.left = ol[SB-1:0];
      res.right = orr[SB-1:0];
      return res;
   endfunction

   task automatic send_sample(logic [SB-1:0] l, logic [SB-1:0] r,
                              logic [tse_pkg::STOP_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'({s, r, l});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(predict_tape_stop(l, r, s));
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [tse_pkg::CSR_INDEX_W-1:0] idx, int unsigned val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= tse_pkg::CFG_W'(val);
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         tse_pkg::CSR_RING_LENGTH: cfg_len = val;
         tse_pkg::CSR_RAMP_SAMPLES: cfg_ramp = val;
         tse_pkg::CSR_ACTIVE_THRESHOLD: cfg_thresh = val;
         default: cfg_stereo = val & 1;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [tse_pkg::STOP_W-1:0] pick_stop();
      case ($urandom_range(5))
         0: return 0;
         1: return tse_pkg::ONE_Q16;
         2: return tse_pkg::STOP_W'($urandom_range(131071));
         3: return tse_pkg::STOP_W'(cfg_thresh + $urandom_range(1));
         default: return tse_pkg::STOP_W'($urandom_range(65536));
      endcase
   endfunction

   // random runs: stretches of held stop amount, some noise
   task automatic run_random(int n);
      logic [tse_pkg::STOP_W-1:0] s;
      int left_in_run;
      left_in_run = 0;
      repeat (n) begin
         if (left_in_run == 0) begin
            s = pick_stop();
            left_in_run = $urandom_range(1, 30);
         end
         send_sample($urandom, $urandom, $urandom_range(9) == 0 ? pick_stop() : s);
         left_in_run--;
      end
   endtask

   task automatic test_directed();
      send_sample(24'h7FFFFF, 24'h800000, 0);
      send_sample(24'h800000, 24'h7FFFFF, 7);
      send_sample(24'h7FFFFF, 24'h7FFFFF, 8);
      send_sample(24'h800000, 24'h800000, 32768);
      send_sample(24'h123456, 24'hFEDCBA, tse_pkg::ONE_Q16);
      send_sample(24'h000001, 24'hFFFFFF, 17'h1FFFF);
      send_sample(24'h555555, 24'hAAAAAA, 100);
      send_sample(24'h000000, 24'h000000, 0);
      drain();
   endtask

   task automatic test_short_ring();
      write_reg(tse_pkg::CSR_RING_LENGTH, 0);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 0);
      write_reg(tse_pkg::CSR_ACTIVE_THRESHOLD, 0);
      write_reg(tse_pkg::CSR_STEREO_ENABLE, 0);
      for (int i = 0; i < 8; i++) send_sample($urandom, $urandom, i < 4 ? 20000 : 1);
      drain();
      write_reg(tse_pkg::CSR_RING_LENGTH, 5);
      write_reg(tse_pkg::CSR_STEREO_ENABLE, 1);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 3);
      run_random(150);
      drain();
   endtask

   task automatic test_ring_shrink();
      write_reg(tse_pkg::CSR_RING_LENGTH, 40);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 10);
      write_reg(tse_pkg::CSR_ACTIVE_THRESHOLD, 65536);
      run_random(60);
      drain();
      write_reg(tse_pkg::CSR_RING_LENGTH, 9);
      write_reg(tse_pkg::CSR_ACTIVE_THRESHOLD, 300);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 65535);
      run_random(150);
      drain();
   endtask

   task automatic test_full_range();
      write_reg(tse_pkg::CSR_RING_LENGTH, 262143);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 1);
      write_reg(tse_pkg::CSR_ACTIVE_THRESHOLD, 7);
      run_random(150);
      drain();
      write_reg(tse_pkg::CSR_RING_LENGTH, 64);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 20);
      write_reg(tse_pkg::CSR_STEREO_ENABLE, 0);
      run_random(200);
      drain();
      write_reg(tse_pkg::CSR_STEREO_ENABLE, 1);
   endtask

   task automatic test_backpressure();
      fork
         begin
            recv_hold = 1;
            repeat (400) @(posedge clock);
            recv_hold = 0;
         end
         run_random(8);
      join
      run_random(100);
      drain();
   endtask

   // result checker
   always @(posedge clock) begin
      pair_type r, e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         r = rsp_tdata[2*SB-1:0];
         got++;
         if (expected_q.size() == 0) begin
            $display("unexpected result transaction");
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (r.left !== e.left) report("left_out", $signed(e.left), $signed(r.left));
            if (r.right !== e.right) report("right_out", $signed(e.right), $signed(r.right));
         end
      end
   end

   always @(posedge clock) rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         hist_l[i] = 0;
         hist_r[i] = 0;
      end
      wr_idx = 0; rd_pos = 0; engaged_prev = 0;
      speed = longint'(1) << 32; speed_goal = tse_pkg::ONE_Q16; speed_step = 0; ramp_left = 0;
      cfg_len = tse_pkg::RST_RING_LENGTH; cfg_ramp = tse_pkg::RST_RAMP_SAMPLES;
      cfg_thresh = tse_pkg::RST_ACTIVE_THRESHOLD; cfg_stereo = 1;
      errors = 0; sent = 0; got = 0; idle_cycles = 0; recv_hold = 0;
      send_idle_pct = 10; recv_idle_pct = 45;
      repeat (11) @(posedge clock);
      reset <= 0;
      test_directed();
      test_short_ring();
      test_ring_shrink();
      send_idle_pct = 45; recv_idle_pct = 10;
      test_full_range();
      test_backpressure();
      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(tse_pkg::CSR_RING_LENGTH, 131072);
      write_reg(tse_pkg::CSR_RAMP_SAMPLES, 4);
      run_random(370);
      drain();
      $display("%0d sample pairs sent, %0d checked, ring lengths 2 to full depth,", sent, got);
      $display("dry, engaged, ramped and instant rate changes, mono and stereo");
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
